### hdl/dqfp32_pkg.sv
// ----------------------------------------------------------------------------
// dqfp32_pkg: shared types and decode functions
// Format codes, register indexes and the element conversion functions.
// ----------------------------------------------------------------------------
package dqfp32_pkg;

  typedef enum logic [1:0] {
    FMT_FP32  = 2'd0,
    FMT_FP16  = 2'd1,
    FMT_BF16  = 2'd2,
    FMT_MXFP4 = 2'd3
  } fmt_t;

  localparam logic [0:0] REG_SOURCE_FORMAT     = 1'd0;
  localparam logic [0:0] REG_HIGH_NIBBLE_FIRST = 1'd1;

  localparam logic [31:0] EXP_ALL_ONES = 32'h7F80_0000;

  // Expand binary16 to binary32; subnormals normalised by a priority search.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       sgn;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] lz;
    logic [9:0] man_n;
    logic [7:0] ex_n;
    begin
      sgn   = h[15];
      ex    = h[14:10];
      man   = h[9:0];
      lz    = 4'd0;
      for (int i = 0; i < 10; i++) begin
        if (man[i]) lz = 4'(9 - i);
      end
      man_n = 10'(man << (lz + 4'd1));
      ex_n  = 8'(8'd113 - 8'(lz) - 8'd1);
      if (ex == 5'd0) begin
        if (man == 10'd0) half_to_single = {sgn, 31'd0};
        else half_to_single = {sgn, ex_n, man_n, 13'd0};
      end else if (ex == 5'h1F) begin
        half_to_single = {sgn, 31'd0} | EXP_ALL_ONES | {9'd0, man, 13'd0};
      end else begin
        half_to_single = {sgn, 8'(8'(ex) + 8'd112), man, 13'd0};
      end
    end
  endfunction

  // One E2M1 nibble scaled by 2^(scale-127).
  function automatic logic [31:0] fp4_scaled(input logic [3:0] nib, input logic [7:0] scale);
    logic        sgn;
    logic [2:0]  mag;
    logic [9:0]  biased;
    logic        mbit;
    logic [23:0] sig;
    begin
      sgn  = nib[3];
      mag  = nib[2:0];
      mbit = (mag == 3'd1) ? 1'b0 : mag[0];
      if (mag == 3'd1) biased = 10'(scale) - 10'd1;
      else biased = 10'(scale) + 10'(mag[2:1]) - 10'd1;
      sig  = {1'b1, mbit, 22'd0};
      if (scale == 8'hFF || scale == 8'h00 || mag == 3'd0)
        fp4_scaled = {sgn, 31'd0};
      else if (biased >= 10'd255)
        fp4_scaled = {sgn, 31'd0} | EXP_ALL_ONES;
      else if (biased >= 10'd1)
        fp4_scaled = {sgn, biased[7:0], mbit, 22'd0};
      else
        fp4_scaled = {sgn, 8'd0, sig[23:1]};  // only scale 1, mag 1 lands here
    end
  endfunction

endpackage

### hdl/dequantize_to_fp32.sv
// ----------------------------------------------------------------------------
// dequantize_to_fp32: raw word to binary32 converter
// Decodes fp32, fp16, bf16 and MXFP4 words into binary32 bit patterns.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready with raw_word, block_scale and
//   single_element; results leave on out_valid/out_ready as value_bits plus
//   last_of_item. Configuration writes arrive on cfg_valid/cfg_ready with
//   cfg_index (0 source_format, 1 high_nibble_first) and cfg_data; they are
//   always taken and must only be issued while the block is idle.
//   A result is registered and appears in the cycle after its request is accepted.
//   fp32/fp16/bf16 requests and MXFP4 odd tails are taken one per cycle while
//   out_ready stays high; an MXFP4 pair holds the single result register,
//   which presents the earlier nibble and then the later one.
//   A new request is taken in the same cycle that the last result of the
//   held one is taken, so back-to-back traffic flows without bubbles.
//   When the receiver stalls the result register holds and in_ready drops.
//   Reset clears both registers to zero and empties the result register.
// ----------------------------------------------------------------------------
module dequantize_to_fp32
  import dqfp32_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] raw_word,
  input  logic [7:0]  block_scale,
  input  logic        single_element,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value_bits,
  output logic        last_of_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  logic [1:0]  source_format;
  logic        high_nibble_first;
  logic [31:0] first_bits;
  logic [31:0] second_bits;
  logic [31:0] pend_bits;     // later nibble waiting behind the shown result
  logic        pend;
  logic        in_fire;

  dqfp32_decode u_decode (
    .fmt         (source_format),
    .hnf         (high_nibble_first),
    .raw_word    (raw_word),
    .block_scale (block_scale),
    .first_bits  (first_bits),
    .second_bits (second_bits)
  );

  assign cfg_ready = 1'b1;
  // Take a new request whenever the output empties this cycle and no second
  // nibble is still to be shown.
  assign in_ready  = !pend && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format     <= 2'd0;
      high_nibble_first <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SOURCE_FORMAT) source_format <= cfg_data[1:0];
      else if (cfg_index == REG_HIGH_NIBBLE_FIRST) high_nibble_first <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (in_fire) begin
      out_valid    <= 1'b1;
      value_bits   <= first_bits;
      pend_bits    <= second_bits;
      pend         <= (fmt_t'(source_format) == FMT_MXFP4) && !single_element;
      last_of_item <= !((fmt_t'(source_format) == FMT_MXFP4) && !single_element);
    end else if (out_ready && pend) begin
      // advance to the later nibble
      value_bits   <= pend_bits;
      last_of_item <= 1'b1;
      pend         <= 1'b0;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
endmodule

### hdl/dqfp32_decode.sv
// ----------------------------------------------------------------------------
// dqfp32_decode: element decoder
// Converts the offered request into its first and second binary32 results.
// ----------------------------------------------------------------------------
module dqfp32_decode
  import dqfp32_pkg::*;
(
  input  logic [1:0]  fmt,
  input  logic        hnf,
  input  logic [31:0] raw_word,
  input  logic [7:0]  block_scale,
  output logic [31:0] first_bits,
  output logic [31:0] second_bits
);
  logic [3:0] nib_a;
  logic [3:0] nib_b;

  assign nib_a = hnf ? raw_word[7:4] : raw_word[3:0];
  assign nib_b = hnf ? raw_word[3:0] : raw_word[7:4];
  assign second_bits = fp4_scaled(nib_b, block_scale);

  always_comb begin
    unique case (fmt_t'(fmt))
      FMT_FP32:  first_bits = raw_word;
      FMT_FP16:  first_bits = half_to_single(raw_word[15:0]);
      FMT_BF16:  first_bits = {raw_word[15:0], 16'd0};
      FMT_MXFP4: first_bits = fp4_scaled(nib_a, block_scale);
      default:   first_bits = raw_word;
    endcase
  end
endmodule

### hdl/dqfp32_checker.sv
// ----------------------------------------------------------------------------
// dqfp32_checker: port-level checks
// Watches the ports of the top level over time.
// ----------------------------------------------------------------------------
module dqfp32_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value_bits,
  input logic        last_of_item
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_bits))
    else $error("result dropped while stalled");

  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_accept_gives_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  a_first_then_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_item |=> out_valid && last_of_item)
    else $error("earlier nibble not followed by final one");
endmodule

bind dequantize_to_fp32 dqfp32_checker u_dqfp32_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .value_bits   (value_bits),
  .last_of_item (last_of_item)
);

### tb/dequantize_to_fp32_tb.sv
// ----------------------------------------------------------------------------
// dequantize_to_fp32_tb: self-checking bench for the binary32 dequantizer
// Walks a directed table of corner requests, then random phases in every
// source format. Each request is predicted by a local decoder and every
// result is checked in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module dequantize_to_fp32_tb;
  import dqfp32_pkg::*;

  // One expected result: binary32 pattern and the end-of-request flag
  typedef struct packed {
    logic [31:0] bits;
    logic        last;
  } elem_t;

  // Directed row: setting, payload and, where obvious, the typed-in answer
  typedef struct packed {
    fmt_t        fmt;
    logic        hnf;
    logic [31:0] raw;
    logic [7:0]  scale;
    logic        single;
    logic        typed;
    logic [31:0] e0;
    logic [31:0] e1;
  } dir_row_t;

  localparam int NUM_DIR    = 22;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_REQS = 75;

  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    // fp32 passes all bits through
    '{FMT_FP32,  1'b0, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0},
    '{FMT_FP32,  1'b0, 32'h0000_0000, 8'hFF, 1'b0, 1'b1, 32'h0000_0000, 32'h0},
    // fp16: infinities, NaN, subnormals, one, ignored high half, largest normal
    '{FMT_FP16,  1'b0, 32'h0000_7C00, 8'h00, 1'b0, 1'b1, 32'h7F80_0000, 32'h0},
    '{FMT_FP16,  1'b0, 32'h0000_FC00, 8'h00, 1'b0, 1'b1, 32'hFF80_0000, 32'h0},
    '{FMT_FP16,  1'b0, 32'h0000_7E01, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
    '{FMT_FP16,  1'b0, 32'h0000_0001, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
    '{FMT_FP16,  1'b0, 32'h0000_83FF, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
    '{FMT_FP16,  1'b0, 32'h0000_3C00, 8'h00, 1'b0, 1'b1, 32'h3F80_0000, 32'h0},
    '{FMT_FP16,  1'b0, 32'hFFFF_0000, 8'hFF, 1'b1, 1'b1, 32'h0000_0000, 32'h0},
    '{FMT_FP16,  1'b0, 32'h0000_7BFF, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
    // bf16: shift up, high half ignored
    '{FMT_BF16,  1'b0, 32'hABCD_1234, 8'h00, 1'b0, 1'b1, 32'h1234_0000, 32'h0},
    '{FMT_BF16,  1'b0, 32'h0000_FFFF, 8'h00, 1'b0, 1'b1, 32'hFFFF_0000, 32'h0},
    // mxfp4, low nibble first: unit scale, zero scales, overflow, smallest
    '{FMT_MXFP4, 1'b0, 32'h0000_0021, 8'd127, 1'b0, 1'b1, 32'h3F00_0000, 32'h3F80_0000},
    '{FMT_MXFP4, 1'b0, 32'h0000_009F, 8'hFF, 1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000},
    '{FMT_MXFP4, 1'b0, 32'h0000_0071, 8'h00, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{FMT_MXFP4, 1'b0, 32'h0000_0077, 8'd254, 1'b0, 1'b1, 32'h7F80_0000, 32'h7F80_0000},
    '{FMT_MXFP4, 1'b0, 32'hFFFF_FF01, 8'h01, 1'b1, 1'b1, 32'h0040_0000, 32'h0},
    '{FMT_MXFP4, 1'b0, 32'h0000_00FE, 8'hFE, 1'b0, 1'b0, 32'h0, 32'h0},
    // mxfp4, high nibble first: order swap and odd tail
    '{FMT_MXFP4, 1'b1, 32'h0000_0012, 8'd127, 1'b0, 1'b1, 32'h3F00_0000, 32'h3F80_0000},
    '{FMT_MXFP4, 1'b1, 32'h0000_00F3, 8'd130, 1'b1, 1'b0, 32'h0, 32'h0},
    '{FMT_MXFP4, 1'b1, 32'h0000_0089, 8'h01, 1'b0, 1'b0, 32'h0, 32'h0},
    '{FMT_MXFP4, 1'b1, 32'h0000_00C5, 8'd253, 1'b0, 1'b0, 32'h0, 32'h0}
  };

  localparam fmt_t PHASE_FMT [NUM_PHASES] = '{
    FMT_MXFP4, FMT_FP32, FMT_FP16, FMT_MXFP4, FMT_BF16,
    FMT_MXFP4, FMT_FP16, FMT_MXFP4, FMT_FP32, FMT_MXFP4
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] raw_word = '0;
  logic [7:0]  block_scale = '0;
  logic        single_element = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value_bits;
  logic        last_of_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  // Local copy of the two registers, updated on each accepted write
  fmt_t  mdl_fmt = FMT_FP32;
  logic  mdl_hnf = 1'b0;

  elem_t pending_q[$];
  int    mismatches = 0;
  int    hold_left = 0;
  bit    long_hold_req = 1'b0;

  // Typed-in answer for the request currently offered, if any
  bit          cur_typed = 1'b0;
  logic [31:0] cur_e0 = '0;
  logic [31:0] cur_e1 = '0;

  dequantize_to_fp32 u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .raw_word      (raw_word),
    .block_scale   (block_scale),
    .single_element(single_element),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .value_bits    (value_bits),
    .last_of_item  (last_of_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // Widen binary16 to binary32; normalise subnormals by shifting up
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sgn;
    logic [7:0]  ex;
    logic [10:0] man;
    begin
      sgn = {h[15], 31'd0};
      man = {1'b0, h[9:0]};
      if (h[14:10] == 5'd0) begin
        if (man == 11'd0) return sgn;
        ex = 8'd113;
        while (!man[10]) begin
          man = man << 1;
          ex  = ex - 8'd1;
        end
        return sgn | {1'b0, ex, man[9:0], 13'd0};
      end
      if (h[14:10] == 5'h1F) return sgn | 32'h7F80_0000 | {9'd0, man[9:0], 13'd0};
      return sgn | {1'b0, 8'(h[14:10]) + 8'd112, man[9:0], 13'd0};
    end
  endfunction

  // E2M1 nibble times 2^(scale-127)
  function automatic logic [31:0] scale_nibble(input logic [3:0] nib, input logic [7:0] sc);
    logic [31:0] sgn;
    int          ex;
    int          biased;
    logic        mbit;
    logic [23:0] sig;
    begin
      sgn = {nib[3], 31'd0};
      if (sc == 8'hFF || sc == 8'h00 || nib[2:0] == 3'd0) return sgn;
      if (nib[2:0] == 3'd1) begin
        ex   = -1;
        mbit = 1'b0;
      end else begin
        ex   = (int'(nib[2:0]) - 2) >>> 1;
        mbit = nib[0];
      end
      biased = int'(sc) + ex;
      if (biased >= 255) return sgn | 32'h7F80_0000;
      if (biased >= 1) return sgn | {1'b0, 8'(biased), mbit, 22'd0};
      sig = {1'b1, mbit, 22'd0};
      if (1 - biased > 24) return sgn;
      return sgn | 32'(sig >> (1 - biased));
    end
  endfunction

  // Queue the results that one accepted request should cause
  task automatic predict_request(input logic [31:0] raw, input logic [7:0] sc,
                                 input logic single);
    logic [3:0] early;
    logic [3:0] late;
    begin
      early = mdl_hnf ? raw[7:4] : raw[3:0];
      late  = mdl_hnf ? raw[3:0] : raw[7:4];
      case (mdl_fmt)
        FMT_FP32: pending_q.push_back('{raw, 1'b1});
        FMT_FP16: pending_q.push_back('{widen_half(raw[15:0]), 1'b1});
        FMT_BF16: pending_q.push_back('{{raw[15:0], 16'd0}, 1'b1});
        default: begin
          if (single) begin
            pending_q.push_back('{scale_nibble(early, sc), 1'b1});
          end else begin
            pending_q.push_back('{scale_nibble(early, sc), 1'b0});
            pending_q.push_back('{scale_nibble(late, sc), 1'b1});
          end
        end
      endcase
      // Where the answer is typed into the table, it replaces the prediction
      if (cur_typed) begin
        if (mdl_fmt == FMT_MXFP4 && !single) begin
          pending_q[pending_q.size()-2].bits = cur_e0;
          pending_q[pending_q.size()-1].bits = cur_e1;
        end else begin
          pending_q[pending_q.size()-1].bits = cur_e0;
        end
      end
    end
  endtask

  // Check results first: a result accepted here cannot belong to a request
  // accepted at the same edge, since the block registers its result.
  always @(posedge clk) begin
    elem_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value_bits=%h last_of_item=%b",
                     value_bits, last_of_item);
        end else begin
          want = pending_q.pop_front();
          if (value_bits !== want.bits || last_of_item !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h/%b, got %h/%b",
                       want.bits, want.last, value_bits, last_of_item);
          end
        end
      end
      if (in_valid && in_ready) predict_request(raw_word, block_scale, single_element);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SOURCE_FORMAT) mdl_fmt = fmt_t'(cfg_data[1:0]);
        else mdl_hnf = cfg_data[0];
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    begin
      r = $urandom_range(0, 15);
      if (r < 10) return 0;
      if (r < 15) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
    end
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      hold_left = pick_gap();
      out_ready <= (hold_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one request and hold it until taken; drop valid only for a gap
  task automatic send_request(input logic [31:0] raw, input logic [7:0] sc,
                              input logic single);
    int g;
    begin
      in_valid       <= 1'b1;
      raw_word       <= raw;
      block_scale    <= sc;
      single_element <= single;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
      g = pick_gap();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  endtask

  // Write a register once the block has drained; upper data bits are junk
  task automatic write_reg(input logic idx, input logic [1:0] val);
    logic [31:0] d;
    begin
      in_valid <= 1'b0;
      while (pending_q.size() != 0) @(negedge clk);
      repeat (3) @(negedge clk);
      d = $urandom;
      d[1:0] = (idx == REG_HIGH_NIBBLE_FIRST) ? {d[1], val[0]} : val;
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= d;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  // Scale byte: random half the time, else a boundary value or the unit scale
  function automatic logic [7:0] pick_scale();
    begin
      case ($urandom_range(0, 9))
        0: return 8'h00;
        1: return 8'hFF;
        2: return 8'h01;
        3: return 8'hFE;
        4: return 8'd127;
        default: return 8'($urandom);
      endcase
    end
  endfunction

  initial begin
    int wait_cycles;
    // Hold reset, then release it at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: rewrite the registers only where a row changes them
    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].fmt != mdl_fmt) write_reg(REG_SOURCE_FORMAT, DIR_TAB[i].fmt);
      if (DIR_TAB[i].hnf != mdl_hnf) write_reg(REG_HIGH_NIBBLE_FIRST, {1'b0, DIR_TAB[i].hnf});
      cur_typed = DIR_TAB[i].typed;
      cur_e0    = DIR_TAB[i].e0;
      cur_e1    = DIR_TAB[i].e1;
      send_request(DIR_TAB[i].raw, DIR_TAB[i].scale, DIR_TAB[i].single);
    end
    cur_typed = 1'b0;

    // Random phases across every format and both nibble orders
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_SOURCE_FORMAT, PHASE_FMT[p]);
      write_reg(REG_HIGH_NIBBLE_FIRST, {1'b0, p[1]});
      // Stall the receiver for a long stretch so the input backs up
      if (p == 3) long_hold_req = 1'b1;
      for (int k = 0; k < PHASE_REQS; k++)
        send_request($urandom, pick_scale(), ($urandom_range(0, 3) == 0));
    end

    // Drain, with a bound, then wait for stray output
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_q.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    if (pending_q.size() != 0) mismatches++;
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #(12 * 600000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### dequantize_to_fp32.f
hdl/dqfp32_pkg.sv
hdl/dqfp32_decode.sv
hdl/dequantize_to_fp32.sv
hdl/dqfp32_checker.sv
tb/dequantize_to_fp32_tb.sv
